// File: sv/rtwc_pkg.sv
// shared types, constants and helpers for the route time window checker
package rtwc_pkg;

    localparam int TIME_WIDTH     = 26;
    localparam int LEG_WIDTH      = 24;
    localparam int LOAD_WIDTH     = 16;
    localparam int CAP_WIDTH      = 16;
    localparam int LOAD_SUM_WIDTH = LOAD_WIDTH + 1;
    localparam int LOAD_CALC_WIDTH = LOAD_SUM_WIDTH + 1;
    localparam int SUM_WIDTH      = (TIME_WIDTH > LEG_WIDTH ? TIME_WIDTH : LEG_WIDTH) + 1;

    localparam int S_FIELD_BITS   = LEG_WIDTH + LOAD_WIDTH + 2 * TIME_WIDTH;
    localparam int S_TDATA_WIDTH  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS   = 2 + 3 * TIME_WIDTH;
    localparam int M_TDATA_WIDTH  = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam int PDATA_WIDTH    = (TIME_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_LSB       = (TIME_WIDTH > 32) ? 3 : 2;
    localparam int REG_IDX_WIDTH  = 2;
    localparam int PADDR_WIDTH    = ADDR_LSB + REG_IDX_WIDTH;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [SUM_WIDTH-1:0]  tsum_t;

    localparam time_t TIME_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DURATION = 2'd1,
        ST_WINDOW   = 2'd2,
        ST_CAPACITY = 2'd3
    } status_t;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_DEPOT_OPEN       = 2'd0,
        REG_DEPOT_CLOSE      = 2'd1,
        REG_MAX_DURATION     = 2'd2,
        REG_VEHICLE_CAPACITY = 2'd3
    } reg_idx_t;

    typedef struct packed {
        time_t                 depot_open;
        time_t                 depot_close;
        time_t                 max_duration;
        logic [CAP_WIDTH-1:0]  vehicle_capacity;
    } cfg_t;

    // leg_time sits in the lowest bits, same order as the stream word
    typedef struct packed {
        logic                          last_stop;
        time_t                         window_close;
        time_t                         window_open;
        logic signed [LOAD_WIDTH-1:0]  load_change;
        logic [LEG_WIDTH-1:0]          leg_time;
    } stop_t;

    typedef struct packed {
        status_t fail_code;
        time_t   earliest;
        time_t   latest;
        time_t   elapsed;
    } finish_t;

    // status sits in the lowest bits, same order as the stream word
    typedef struct packed {
        time_t   route_duration;
        time_t   start_latest;
        time_t   start_earliest;
        status_t status;
    } result_t;

    function automatic time_t sub_floor(time_t a, time_t b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// File: sv/rtwc_cfg.sv
// configuration register file with apb-style access
module rtwc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtwc_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [rtwc_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [rtwc_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                              pready,
    output rtwc_pkg::cfg_t                    cfg
);
    import rtwc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[ADDR_LSB +: REG_IDX_WIDTH]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depot_open       <= '0;
            cfg_reg.depot_close      <= TIME_MAX;
            cfg_reg.max_duration     <= TIME_MAX;
            cfg_reg.vehicle_capacity <= '1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (idx)
                REG_DEPOT_OPEN:       cfg_reg.depot_open       <= pwdata[TIME_WIDTH-1:0];
                REG_DEPOT_CLOSE:      cfg_reg.depot_close      <= pwdata[TIME_WIDTH-1:0];
                REG_MAX_DURATION:     cfg_reg.max_duration     <= pwdata[TIME_WIDTH-1:0];
                REG_VEHICLE_CAPACITY: cfg_reg.vehicle_capacity <= pwdata[CAP_WIDTH-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DEPOT_OPEN:       prdata = PDATA_WIDTH'(cfg_reg.depot_open);
            REG_DEPOT_CLOSE:      prdata = PDATA_WIDTH'(cfg_reg.depot_close);
            REG_MAX_DURATION:     prdata = PDATA_WIDTH'(cfg_reg.max_duration);
            REG_VEHICLE_CAPACITY: prdata = PDATA_WIDTH'(cfg_reg.vehicle_capacity);
            default:              prdata = '0;
        endcase
    end

endmodule

// File: sv/rtwc_step.sv
// per-stop update of the route times, load and fail code
module rtwc_step (
    input  logic              clk,
    input  logic              rst_n,
    input  rtwc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    input  rtwc_pkg::stop_t   item,
    output logic              take,
    input  logic              fin_ready,
    output logic              fin_valid,
    output rtwc_pkg::finish_t fin
);
    import rtwc_pkg::*;

    localparam logic signed [LOAD_CALC_WIDTH-1:0] LOAD_HI =
        LOAD_CALC_WIDTH'((2 ** (LOAD_SUM_WIDTH - 1)) - 1);
    localparam logic signed [LOAD_CALC_WIDTH-1:0] LOAD_LO = LOAD_CALC_WIDTH'(-LOAD_HI - 1);

    function automatic time_t sat_add(tsum_t a, tsum_t b);
        tsum_t s;
        s = a + b;
        if (s > tsum_t'(TIME_MAX))
            return TIME_MAX;
        return s[TIME_WIDTH-1:0];
    endfunction

    time_t                              earliest_reg, earliest_next;
    time_t                              latest_reg, latest_next;
    time_t                              elapsed_reg, elapsed_next;
    logic signed [LOAD_SUM_WIDTH-1:0]   load_reg, load_next;
    status_t                            fail_reg, fail_next;
    logic                               in_route_reg;
    logic                               fin_valid_reg, fin_valid_next;
    finish_t                            fin_reg;

    // route start values
    time_t                              e0, l0, el0;
    logic signed [LOAD_SUM_WIDTH-1:0]   load0;
    status_t                            fail0;
    // after the leg
    time_t                              e1, l1, el1;
    logic signed [LOAD_CALC_WIDTH-1:0]  load_wide;
    logic signed [LOAD_CALC_WIDTH-1:0]  cap_wide;

    assign take      = in_valid && (!item.last_stop || !fin_valid_reg || fin_ready);
    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    always_comb
    begin
        e0    = in_route_reg ? earliest_reg : cfg.depot_open;
        l0    = in_route_reg ? latest_reg   : cfg.depot_close;
        el0   = in_route_reg ? elapsed_reg  : '0;
        load0 = in_route_reg ? load_reg     : '0;
        fail0 = in_route_reg ? fail_reg     : ST_OK;

        e1  = sat_add(tsum_t'(e0),  tsum_t'(item.leg_time));
        l1  = sat_add(tsum_t'(l0),  tsum_t'(item.leg_time));
        el1 = sat_add(tsum_t'(el0), tsum_t'(item.leg_time));

        load_wide = LOAD_CALC_WIDTH'(load0) + LOAD_CALC_WIDTH'(item.load_change);
        cap_wide  = $signed({{(LOAD_CALC_WIDTH - CAP_WIDTH){1'b0}}, cfg.vehicle_capacity});

        earliest_next = e0;
        latest_next   = l0;
        elapsed_next  = el0;
        load_next     = load0;
        fail_next     = fail0;

        if (fail0 == ST_OK)
        begin
            earliest_next = e1;
            latest_next   = l1;
            elapsed_next  = el1;
            priority if (el1 > cfg.max_duration)
            begin
                fail_next = ST_DURATION;
            end
            else if (e1 > item.window_close)
            begin
                fail_next = ST_WINDOW;
            end
            else
            begin
                if (l1 < item.window_open)
                begin
                    // whole window lies ahead: wait for the opening
                    elapsed_next  = sat_add(tsum_t'(el1),
                                            tsum_t'(sub_floor(item.window_open, e1)));
                    earliest_next = item.window_open;
                    latest_next   = item.window_open;
                end
                else
                begin
                    if (item.window_open > e1)
                        earliest_next = item.window_open;
                    if (item.window_close < l1)
                        latest_next = item.window_close;
                end
                if (load_wide > cap_wide)
                    fail_next = ST_CAPACITY;
                priority if (load_wide > LOAD_HI)
                    load_next = LOAD_HI[LOAD_SUM_WIDTH-1:0];
                else if (load_wide < LOAD_LO)
                    load_next = LOAD_LO[LOAD_SUM_WIDTH-1:0];
                else
                    load_next = load_wide[LOAD_SUM_WIDTH-1:0];
            end
        end

        priority if (take && item.last_stop)
            fin_valid_next = 1'b1;
        else if (fin_ready)
            fin_valid_next = 1'b0;
        else
            fin_valid_next = fin_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_route_reg  <= 1'b0;
            fail_reg      <= ST_OK;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            if (take)
            begin
                in_route_reg <= !item.last_stop;
                fail_reg     <= fail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            earliest_reg <= earliest_next;
            latest_reg   <= latest_next;
            elapsed_reg  <= elapsed_next;
            load_reg     <= load_next;
            if (item.last_stop)
            begin
                fin_reg.fail_code <= fail_next;
                fin_reg.earliest  <= earliest_next;
                fin_reg.latest    <= latest_next;
                fin_reg.elapsed   <= elapsed_next;
            end
        end
    end

    // a latched violation holds for the rest of the route
    assert property (@(posedge clk) disable iff (!rst_n)
        take && in_route_reg && fail_reg != ST_OK && !item.last_stop
        |=> fail_reg == $past(fail_reg))
        else $error("fail code changed after a violation");

    // the last stop closes the route
    assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last_stop |=> !in_route_reg && fin_valid_reg)
        else $error("route not closed at last stop");

    // a pending finish word is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !fin_ready |=> fin_valid_reg && $stable(fin_reg))
        else $error("finish word lost while stalled");

endmodule

// File: sv/rtwc_result.sv
// final duration check, departure window and result register
module rtwc_result (
    input  logic              clk,
    input  logic              rst_n,
    input  rtwc_pkg::time_t   max_duration,
    input  logic              fin_valid,
    input  rtwc_pkg::finish_t fin,
    output logic              fin_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rtwc_pkg::result_t result
);
    import rtwc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t result_reg, result_next;
    status_t status_final;

    assign fin_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        // waiting at the return depot can still push the duration over
        if (fin.fail_code == ST_OK && fin.elapsed > max_duration)
            status_final = ST_DURATION;
        else
            status_final = fin.fail_code;

        result_next.status = status_final;
        if (status_final == ST_OK)
        begin
            result_next.start_earliest = sub_floor(fin.earliest, fin.elapsed);
            result_next.start_latest   = sub_floor(fin.latest, fin.elapsed);
            result_next.route_duration = fin.elapsed;
        end
        else
        begin
            result_next.start_earliest = '0;
            result_next.start_latest   = '0;
            result_next.route_duration = '0;
        end

        priority if (fin_valid && fin_ready)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
            result_reg <= result_next;
    end

endmodule

// File: sv/route_time_window_check_unit.sv
// top level of the route time window feasibility checker
// the last stop of a route gives its result word on m_tvalid after it is accepted, by way
//   of the input register (loaded at the accepting edge), the route update's finish register
//   and the result register
// throughput: one stop word per cycle, no stall unless the result side backs up
// reset: rst_n clears all valid flags and the route state and loads the register defaults;
//   there is no clearing pass, the block takes words from the first cycle after reset
module route_time_window_check_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtwc_pkg::PADDR_WIDTH-1:0]    paddr,
    input  logic [rtwc_pkg::PDATA_WIDTH-1:0]    pwdata,
    output logic [rtwc_pkg::PDATA_WIDTH-1:0]    prdata,
    output logic                                pready,
    // stop words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // leg_time, load_change, window_open, window_close, zero pad
    input  logic [rtwc_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
    // last_stop
    input  logic                                s_tlast,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, start_earliest, start_latest, route_duration
    output logic [rtwc_pkg::M_TDATA_WIDTH-1:0]  m_tdata
);
    import rtwc_pkg::*;

    cfg_t    cfg;
    logic    in_valid_reg, in_valid_next;
    stop_t   in_item_reg;
    logic    step_take;
    logic    s_accept;
    logic    fin_valid;
    logic    fin_ready;
    finish_t fin;
    result_t result;

    rtwc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register: takes a new word when empty or whenever the held one moves on
    assign s_tready = !in_valid_reg || step_take;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        priority if (s_accept)
            in_valid_next = 1'b1;
        else if (step_take)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_item_reg <= {s_tlast, s_tdata[S_FIELD_BITS-1:0]};
    end

    // route update: one stop per cycle, a last stop waits only for a free finish slot
    rtwc_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .item      (in_item_reg),
        .take      (step_take),
        .fin_ready (fin_ready),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    // result register toward the master side
    rtwc_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_duration (cfg.max_duration),
        .fin_valid    (fin_valid),
        .fin          (fin),
        .fin_ready    (fin_ready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result       (result)
    );

    assign m_tdata = M_TDATA_WIDTH'(result);

endmodule
